// ===== rtl/qrs_pkg.sv =====
// Package: widths, root kind codes and stage payload types of the quadratic root solver.
`default_nettype none
package qrs_pkg;
  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_WIDTH  = 40;
  // |d| < 2^(2*COEF_WIDTH+1), radicand |d|*4^FRAC_BITS
  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 2;
  localparam int RAD_WIDTH  = DISC_WIDTH + 2 * FRAC_BITS;
  localparam int ROOT_WIDTH = RAD_WIDTH / 2;
  // numerator -b*2^F +- S, signed
  localparam int NUM_WIDTH  = ((COEF_WIDTH + FRAC_BITS + 1) > ROOT_WIDTH ?
                               (COEF_WIDTH + FRAC_BITS + 1) : ROOT_WIDTH) + 2;
  localparam int DEN_WIDTH  = COEF_WIDTH + 1;
  localparam int MAG_WIDTH  = NUM_WIDTH - 1;

  typedef enum logic [1:0] {
    KIND_EQUAL    = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_ERROR    = 2'd3
  } root_kind_t;

  // one square root step: bring in two radicand bits, try subtract
  typedef struct packed {
    logic [RAD_WIDTH-1:0]    rad;
    logic [ROOT_WIDTH+1:0]   rem;
    logic [ROOT_WIDTH-1:0]   root;
  } sqrt_state_t;

  typedef struct packed {
    root_kind_t             kind;
    logic signed [COEF_WIDTH-1:0] a;
    logic signed [COEF_WIDTH-1:0] b;
  } tag_t;

  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    sqrt_state_t          o;
    logic [ROOT_WIDTH+1:0] rem;
    logic [ROOT_WIDTH+1:0] trial;
    rem   = {s.rem[ROOT_WIDTH-1:0], s.rad[RAD_WIDTH-1 -: 2]};
    trial = {s.root, 2'b01};
    o.rad = {s.rad[RAD_WIDTH-3:0], 2'b00};
    if (rem >= trial) begin
      o.rem  = rem - trial;
      o.root = {s.root[ROOT_WIDTH-2:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {s.root[ROOT_WIDTH-2:0], 1'b0};
    end
    return o;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/qrs_sqrt.sv =====
// Pipelined integer square root, up to four result bits per stage.
`default_nettype none
module qrs_sqrt import qrs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_vld,
  input  wire logic [RAD_WIDTH-1:0]  in_rad,
  input  wire tag_t                  in_tag,
  output logic                       out_vld,
  output logic [ROOT_WIDTH-1:0]      out_root,
  output tag_t                       out_tag
);
  localparam int STEPS  = 4;
  localparam int NSTAGE = (ROOT_WIDTH + STEPS - 1) / STEPS;

  sqrt_state_t st_r  [NSTAGE];
  tag_t        tag_r [NSTAGE];
  logic [NSTAGE-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NSTAGE-2:0], in_vld};
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    sqrt_state_t src;
    sqrt_state_t s_nxt;
    tag_t        tsrc;
    if (g == 0) begin : g_first
      assign src  = '{rad: in_rad, rem: '0, root: '0};
      assign tsrc = in_tag;
    end else begin : g_rest
      assign src  = st_r[g-1];
      assign tsrc = tag_r[g-1];
    end
    always_comb begin
      s_nxt = src;
      for (int k = 0; k < STEPS; k++)
        if (g * STEPS + k < ROOT_WIDTH) s_nxt = sqrt_step(s_nxt);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g]  <= s_nxt;
        tag_r[g] <= tsrc;
      end
    end
  end

  assign out_vld  = vld_r[NSTAGE-1];
  assign out_root = st_r[NSTAGE-1].root;
  assign out_tag  = tag_r[NSTAGE-1];
endmodule
`default_nettype wire

// ===== rtl/qrs_div.sv =====
// Pipelined signed division, truncating, one quotient bit per step, two quotients.
`default_nettype none
module qrs_div import qrs_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        in_vld,
  input  wire logic signed [NUM_WIDTH-1:0] in_num0,
  input  wire logic signed [NUM_WIDTH-1:0] in_num1,
  input  wire logic signed [DEN_WIDTH-1:0] in_den,
  input  wire root_kind_t                  in_kind,
  output logic                             out_vld,
  output logic [OUT_WIDTH-1:0]             out_q0,
  output logic [OUT_WIDTH-1:0]             out_q1,
  output root_kind_t                       out_kind
);
  localparam int STEPS  = 4;
  localparam int NSTAGE = (MAG_WIDTH + STEPS - 1) / STEPS;
  // signed quotient width, wide enough for both the magnitude and the clamp bounds
  localparam int QW = (MAG_WIDTH + 1 > OUT_WIDTH) ? MAG_WIDTH + 1 : OUT_WIDTH;
  localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (OUT_WIDTH-1)) - 1);
  localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

  typedef struct packed {
    logic [MAG_WIDTH-1:0] n;
    logic [DEN_WIDTH-1:0] r;
    logic                 neg;
  } dv_t;

  typedef struct packed {
    dv_t                  d0;
    dv_t                  d1;
    logic [DEN_WIDTH-1:0] dm;
    root_kind_t           kind;
  } dst_t;

  // shift n left, quotient bit enters at lsb
  function automatic dv_t dstep(dv_t x, logic [DEN_WIDTH-1:0] dm);
    dv_t o;
    logic [DEN_WIDTH:0] r;
    r = {x.r, x.n[MAG_WIDTH-1]};
    o.neg = x.neg;
    if (r >= {1'b0, dm}) begin
      r   = r - {1'b0, dm};
      o.n = {x.n[MAG_WIDTH-2:0], 1'b1};
    end else begin
      o.n = {x.n[MAG_WIDTH-2:0], 1'b0};
    end
    o.r = r[DEN_WIDTH-1:0];
    return o;
  endfunction

  function automatic logic [MAG_WIDTH-1:0] nmag(logic signed [NUM_WIDTH-1:0] v);
    logic [NUM_WIDTH-1:0] m;
    m = v[NUM_WIDTH-1] ? -v : v;
    return m[MAG_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_WIDTH-1:0] fin(dv_t x);
    logic signed [QW-1:0] m;
    logic signed [QW-1:0] q;
    m = $signed(QW'({1'b0, x.n}));
    q = x.neg ? -m : m;
    if (q > Q_HI) q = Q_HI;
    if (q < Q_LO) q = Q_LO;
    return q[OUT_WIDTH-1:0];
  endfunction

  dst_t st_r [NSTAGE];
  logic [NSTAGE-1:0] vld_r;
  logic [DEN_WIDTH-1:0] dm_in;

  assign dm_in = in_den[DEN_WIDTH-1] ? -in_den : in_den;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NSTAGE-2:0], in_vld};
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    dst_t src;
    dst_t s_nxt;
    if (g == 0) begin : g_first
      assign src = '{
        d0: '{n: nmag(in_num0), r: '0, neg: in_num0[NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1]},
        d1: '{n: nmag(in_num1), r: '0, neg: in_num1[NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1]},
        dm: dm_in, kind: in_kind};
    end else begin : g_rest
      assign src = st_r[g-1];
    end
    always_comb begin
      s_nxt = src;
      for (int k = 0; k < STEPS; k++) begin
        if (g * STEPS + k < MAG_WIDTH) begin
          s_nxt.d0 = dstep(s_nxt.d0, src.dm);
          s_nxt.d1 = dstep(s_nxt.d1, src.dm);
        end
      end
    end
    always_ff @(posedge clk) if (adv) st_r[g] <= s_nxt;
  end

  always_comb begin
    out_vld  = vld_r[NSTAGE-1];
    out_kind = st_r[NSTAGE-1].kind;
    if (out_kind == KIND_ERROR) begin
      out_q0 = '0;
      out_q1 = '0;
    end else begin
      out_q0 = fin(st_r[NSTAGE-1].d0);
      out_q1 = fin(st_r[NSTAGE-1].d1);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/quadratic_root_solver.sv =====
// Top level: discriminant, square root and division pipelines.
// Throughput: one coefficient set per cycle; the pipeline stalls as a whole while
// out_valid is high and out_ready is low. Square root and divider are staged, each
// with up to four bit steps per stage, behind the product and discriminant stages.
// Reset (rst_n low, synchronous) clears all valid bits; no result is pending after it.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_root_kind,
  output logic signed [OUT_WIDTH-1:0]       out_first_part,
  output logic signed [OUT_WIDTH-1:0]       out_second_part
);
  logic adv;
  // stage 1: products
  logic s1_vld_r;
  logic signed [2*COEF_WIDTH-1:0] bb_r;
  logic signed [2*COEF_WIDTH+1:0] ac4_r;
  tag_t s1_tag_r;
  // stage 2: discriminant
  logic s2_vld_r;
  logic [DISC_WIDTH-1:0] dmag_r;
  tag_t s2_tag_r;

  logic sq_vld;
  logic [ROOT_WIDTH-1:0] sq_root;
  tag_t sq_tag;

  logic dv_vld;
  logic [OUT_WIDTH-1:0] q0, q1;
  root_kind_t dv_kind;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  logic signed [DISC_WIDTH-1:0] d;
  always_comb d = DISC_WIDTH'(bb_r) - DISC_WIDTH'(ac4_r);

  // stage 1 marks a zero a; stage 2 keeps that and otherwise classifies by d
  root_kind_t kind_nxt;
  always_comb begin
    priority if (s1_tag_r.kind == KIND_ERROR) kind_nxt = KIND_ERROR;
    else if (d == '0)                         kind_nxt = KIND_EQUAL;
    else if (d[DISC_WIDTH-1])                 kind_nxt = KIND_COMPLEX;
    else                                      kind_nxt = KIND_DISTINCT;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb_r  <= in_coef_b * in_coef_b;
      ac4_r <= (2*COEF_WIDTH+2)'(in_coef_a * in_coef_c) <<< 2;
      s1_tag_r.a <= in_coef_a;
      s1_tag_r.b <= in_coef_b;
      s1_tag_r.kind <= (in_coef_a == '0) ? KIND_ERROR : KIND_EQUAL;
      s2_tag_r <= '{kind: kind_nxt, a: s1_tag_r.a, b: s1_tag_r.b};
      dmag_r <= d[DISC_WIDTH-1] ? -d : d;
    end
  end

  qrs_sqrt u_sqrt (
    .clk, .rst_n, .adv,
    .in_vld(s2_vld_r),
    .in_rad(RAD_WIDTH'(dmag_r) << (2*FRAC_BITS)),
    .in_tag(s2_tag_r),
    .out_vld(sq_vld), .out_root(sq_root), .out_tag(sq_tag)
  );

  logic signed [NUM_WIDTH-1:0] nb, sx, n0, n1;
  always_comb begin
    nb = -(NUM_WIDTH'(sq_tag.b) <<< FRAC_BITS);
    sx = $signed(NUM_WIDTH'(sq_root));
    unique case (sq_tag.kind)
      KIND_DISTINCT: begin n0 = nb + sx; n1 = nb - sx; end
      KIND_COMPLEX:  begin n0 = nb;      n1 = sx;      end
      default:       begin n0 = nb;      n1 = nb;      end
    endcase
  end

  qrs_div u_div (
    .clk, .rst_n, .adv,
    .in_vld(sq_vld), .in_num0(n0), .in_num1(n1),
    .in_den(DEN_WIDTH'(sq_tag.a) <<< 1),
    .in_kind(sq_tag.kind),
    .out_vld(dv_vld), .out_q0(q0), .out_q1(q1), .out_kind(dv_kind)
  );

  assign out_valid       = dv_vld;
  assign out_root_kind   = dv_kind;
  assign out_first_part  = q0;
  assign out_second_part = q1;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_part))
    else $error("result changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_ERROR |-> out_first_part == '0 && out_second_part == '0)
    else $error("error result not zero");
  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_EQUAL |-> out_first_part == out_second_part)
    else $error("equal roots differ");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the quadratic root solver: directed table plus random requests vs. a predictor.
`default_nettype none
module tb_top;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1250;
  localparam int CALM_START = 1100;  // no idling from here on

  typedef struct {
    logic signed [COEF_WIDTH-1:0] a;
    logic signed [COEF_WIDTH-1:0] b;
    logic signed [COEF_WIDTH-1:0] c;
  } coefs_t;

  typedef struct packed {
    root_kind_t               kind;
    logic signed [OUT_WIDTH-1:0] first;
    logic signed [OUT_WIDTH-1:0] second;
  } roots_t;

  typedef struct {
    coefs_t co;
    bit     typed;  // expectation given in the table
    roots_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COEF_WIDTH-1:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_root_kind;
  logic signed [OUT_WIDTH-1:0] out_first_part, out_second_part;

  roots_t pending_roots[$];
  row_t   table_rows[$];
  int     n_fail = 0;
  int     n_sent = 0;
  int     n_recv = 0;
  bit     calm = 1'b0;
  bit     hold_out = 1'b0;
  int     kind_seen[4] = '{0, 0, 0, 0};

  quadratic_root_solver DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(sqrt(x)) for x below 2^128
  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] clamp_out(logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (OUT_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_WIDTH-1:0];
  endfunction

  function automatic roots_t solve_roots(coefs_t co);
    roots_t r;
    logic signed [127:0] a, b, c, d, nb, den, s, mag_d;
    a = co.a;
    b = co.b;
    c = co.c;
    if (a == 0) begin
      r.kind = KIND_ERROR;
      r.first = '0;
      r.second = '0;
      return r;
    end
    d = b * b - 4 * a * c;
    mag_d = (d < 0) ? -d : d;
    s = $signed({64'd0, isqrt(mag_d << (2 * FRAC_BITS))});
    den = 2 * a;
    nb = -b * (128'sd1 <<< FRAC_BITS);
    // SV signed division truncates toward zero, as the roots require
    if (d == 0) begin
      r.kind = KIND_EQUAL;
      r.first = clamp_out(nb / den);
      r.second = r.first;
    end else if (d > 0) begin
      r.kind = KIND_DISTINCT;
      r.first = clamp_out((nb + s) / den);
      r.second = clamp_out((nb - s) / den);
    end else begin
      r.kind = KIND_COMPLEX;
      r.first = clamp_out(nb / den);
      r.second = clamp_out(s / den);
    end
    return r;
  endfunction

  function automatic row_t mk_row(int a, int b, int c, bit typed, root_kind_t k,
                                  longint f, longint s);
    row_t r;
    r.co.a = COEF_WIDTH'(a);
    r.co.b = COEF_WIDTH'(b);
    r.co.c = COEF_WIDTH'(c);
    r.typed = typed;
    r.want.kind = k;
    r.want.first = OUT_WIDTH'(f);
    r.want.second = OUT_WIDTH'(s);
    return r;
  endfunction

  function automatic coefs_t rand_coefs();
    coefs_t co;
    int sel;
    int r1, r2, k;
    sel = $urandom_range(0, 9);
    co.a = COEF_WIDTH'($urandom);
    co.b = COEF_WIDTH'($urandom);
    co.c = COEF_WIDTH'($urandom);
    case (sel)
      0: begin
        co.a = 0;
      end
      1, 2: begin
        // factored (k x - r1)(x - r2): real roots, double where r1 = k r2
        k = $urandom_range(1, 20);
        r1 = $signed($urandom_range(0, 200)) - 100;
        r2 = (sel == 2) ? r1 : $signed($urandom_range(0, 200)) - 100;
        co.a = COEF_WIDTH'(k);
        co.b = COEF_WIDTH'(-(k * r2 + r1));
        co.c = COEF_WIDTH'(r1 * r2);
        if ($urandom_range(0, 1)) begin
          co.a = -co.a;
          co.b = -co.b;
          co.c = -co.c;
        end
      end
      3: begin
        // b even, c = b^2/(4a) with a = 1 or -1: double root
        co.a = $urandom_range(0, 1) ? 1 : -1;
        co.b = COEF_WIDTH'(2 * ($signed($urandom_range(0, 360)) - 180));
        co.c = co.a * (co.b / 2) * (co.b / 2);
      end
      4: begin
        co.a = COEF_WIDTH'($signed($urandom_range(0, 6)) - 3);
        co.b = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      5: begin
        co.a = COEF_WIDTH'($signed($urandom_range(0, 64)) - 32);
        co.b = COEF_WIDTH'($signed($urandom_range(0, 64)) - 32);
        co.c = COEF_WIDTH'($signed($urandom_range(0, 64)) - 32);
      end
      default: ;
    endcase
    return co;
  endfunction

  task automatic send_coefs(coefs_t co, bit typed, roots_t want);
    roots_t exp_r;
    exp_r = solve_roots(co);
    if (typed && exp_r != want)
      $display("%0t predictor disagrees with table: exp %0d %0d %0d got %0d %0d %0d",
               $time, want.kind, want.first, want.second,
               exp_r.kind, exp_r.first, exp_r.second);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coef_a <= co.a;
    in_coef_b <= co.b;
    in_coef_c <= co.c;
    do @(posedge clk); while (!in_ready);
    pending_roots.push_back(typed ? want : exp_r);
    n_sent++;
  endtask

  initial begin
    roots_t none;
    none = '{KIND_ERROR, '0, '0};
    table_rows.push_back(mk_row(0, 0, 0, 1, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(0, -32768, 32767, 1, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(1, 0, 0, 1, KIND_EQUAL, 0, 0));
    table_rows.push_back(mk_row(1, -2, 1, 1, KIND_EQUAL, 65536, 65536));
    table_rows.push_back(mk_row(1, -3, 2, 1, KIND_DISTINCT, 2 * 65536, 65536));
    table_rows.push_back(mk_row(1, 0, 1, 1, KIND_COMPLEX, 0, 65536));
    table_rows.push_back(mk_row(-1, 0, -1, 1, KIND_COMPLEX, 0, -65536));
    table_rows.push_back(mk_row(1, -32768, 0, 1, KIND_DISTINCT, 64'sd2147483648, 0));
    table_rows.push_back(mk_row(-32768, -32768, -32768, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(32767, 32767, 32767, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(1, 32767, -32768, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(-1, -32768, 32767, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(-32768, 32767, 32767, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(32767, -32768, 1, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(1, 1, 1, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(-1, 32767, 0, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(-32768, 0, -32768, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(3, 5, -7, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(-5, 1, 0, 0, KIND_ERROR, 0, 0));
    table_rows.push_back(mk_row(2, -2, 1, 0, KIND_ERROR, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i])
      send_coefs(table_rows[i].co, table_rows[i].typed, table_rows[i].want);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_out = 1'b1;
      if (i == CALM_START) calm = 1'b1;
      send_coefs(rand_coefs(), 1'b0, none);
    end
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d coefficient sets, checked %0d results (equal %0d, distinct %0d,",
             n_sent, n_recv, kind_seen[0], kind_seen[1]);
    $display("  complex %0d, a zero %0d), with idling on both sides and one long stall.",
             kind_seen[2], kind_seen[3]);
    if (n_fail == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_valid && out_ready) begin
      n_recv++;
      if (pending_roots.size() == 0) begin
        $display("%0t unexpected result: kind %0d first %0d second %0d", $time,
                 out_root_kind, out_first_part, out_second_part);
        n_fail++;
      end else begin
        want = pending_roots.pop_front();
        kind_seen[want.kind]++;
        if (out_root_kind !== want.kind) begin
          $display("%0t root_kind: expected %0d, actual %0d", $time, want.kind, out_root_kind);
          n_fail++;
        end
        if (out_first_part !== want.first) begin
          $display("%0t first_part: expected %0d, actual %0d", $time, want.first,
                   out_first_part);
          n_fail++;
        end
        if (out_second_part !== want.second) begin
          $display("%0t second_part: expected %0d, actual %0d", $time, want.second,
                   out_second_part);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", pending_roots.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/qrs_pkg.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
tb/tb_top.sv
